FILE: design/drive_command_translator_core_macros.svh
// assertion macros used by the checker file of the drive command translator
// each macro expects a signal named clock in the calling scope, and DCT_ASSERT also reset
`ifndef DRIVE_COMMAND_TRANSLATOR_CORE_MACROS_SVH
`define DRIVE_COMMAND_TRANSLATOR_CORE_MACROS_SVH

// clocked check, quiet while reset is high
`define DCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds across reset
`define DCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/dct_pkg.sv
// shared types and constants of the drive command translator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dct_pkg;

   // frame header and message checks
   localparam logic [31:0] FRAME_MAGIC    = 32'h4741_4E53;
   localparam logic [10:0] MIN_MSG_LEN    = 11'd5;
   localparam int          FRAME_HEAD_LEN = 4;
   localparam int          BODY_MAX       = 5;
   localparam int          FRAME_MAX      = FRAME_HEAD_LEN + BODY_MAX;

   // kinematics constants
   localparam int HALF_WIDTH_CM      = 30;
   localparam int HALF_LENGTH_CM     = 28;
   localparam int SPEED_FULL_SCALE   = 127;
   localparam int SPEED_COMPUTED_MAX = 330;
   localparam int RATE_DIVISOR       = 100;
   localparam int RATE_GAIN          = HALF_WIDTH_CM + HALF_LENGTH_CM;

   // reciprocals for truncating divides, exact over the operand ranges used here
   localparam longint RateRecipL  = ((longint'(RATE_GAIN) << 16) + RATE_DIVISOR - 1)
                                    / RATE_DIVISOR;
   localparam longint SpeedRecipL = ((longint'(SPEED_FULL_SCALE) << 24)
                                    + SPEED_COMPUTED_MAX - 1) / SPEED_COMPUTED_MAX;
   localparam logic [15:0] RATE_RECIP  = 16'(RateRecipL);
   localparam logic [22:0] SPEED_RECIP = 23'(SpeedRecipL);

   // message type codes
   localparam logic [7:0] MSG_CMD0      = 8'd0;
   localparam logic [7:0] MSG_CMD1      = 8'd1;
   localparam logic [7:0] MSG_HORN      = 8'd2;
   localparam logic [7:0] MSG_DRIVE     = 8'd3;
   localparam logic [7:0] MSG_CMD4      = 8'd4;
   localparam logic [7:0] MSG_CMD5      = 8'd5;
   localparam logic [7:0] MSG_MOTOR     = 8'd6;
   localparam logic [7:0] MSG_DRIVE_ALT = 8'd7;
   localparam logic [7:0] MSG_CMD8      = 8'd8;
   localparam logic [7:0] MSG_CMD9      = 8'd9;
   localparam logic [7:0] MSG_CMD10     = 8'd10;

   // body lengths
   localparam logic [2:0] BODY_LEN_NONE  = 3'd0;
   localparam logic [2:0] BODY_LEN_OP    = 3'd1;
   localparam logic [2:0] BODY_LEN_MOTOR = 3'd3;
   localparam logic [2:0] BODY_LEN_DRIVE = 3'd5;

   // decoded frame body handed to the serializer
   typedef struct packed {
      logic                     valid;
      logic [2:0]               body_len;
      logic [BODY_MAX-1:0][7:0] body;
   } frame_type;

endpackage

`default_nettype wire

FILE: design/drive_command_translator_core.sv
// top level of the drive command translator: decode stage and frame serializer
// depends on dct_pkg, dct_decode, dct_wheel and dct_serial
//
//   channel  | direction | contents
//   req_     | in        | one control message per word
//   rsp_     | out       | one frame byte per word, tlast on the final byte
//
// a message is held in the decode register, then its frame of 5 to 9 bytes
// leaves from the serializer shift register at one byte per cycle while
// rsp_tready is high; rejected messages send nothing. the decode register
// can take the next message while the serializer is still sending a frame.
// a new frame loads in the cycle its predecessor's last byte is taken.
// reset clears the valid flags of both stages; rsp_tready low holds the frame
// and, once the decode register is full, req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module drive_command_translator_core
   import dct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // msg_len[10:0], magic_word[42:11], first_arg[50:43],
                                   // second_arg[58:51], third_arg[66:59], zero fill
   input  logic [7:0]  req_tuser,  // cmd_kind[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // frame_byte[7:0]
   output logic        rsp_tlast   // frame_last
);

   frame_type frame;
   logic      frame_ready;

   dct_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .frame      (frame),
      .frame_ready(frame_ready)
   );

   dct_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .frame_ready(frame_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: design/dct_wheel.sv
// scales one wheel velocity by 127/330 with truncation toward zero
// depends on dct_pkg
`timescale 1ns / 1ps
`default_nettype none

module dct_wheel
   import dct_pkg::*;
(
   input  logic signed [9:0] vel,
   output logic [7:0]        speed
);

   logic [8:0]  mag;
   logic [31:0] prod;
   logic [6:0]  quot;

   always_comb begin
      mag   = vel[9] ? 9'(10'd0 - vel) : vel[8:0];
      prod  = {23'd0, mag} * {9'd0, SPEED_RECIP};
      quot  = prod[30:24];
      speed = vel[9] ? (8'd0 - {1'b0, quot}) : {1'b0, quot};
   end

endmodule

`default_nettype wire

FILE: design/dct_decode.sv
// input register and message decode: checks, opcode selection, wheel speeds
// depends on dct_pkg and dct_wheel
`timescale 1ns / 1ps
`default_nettype none

module dct_decode
   import dct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [7:0]  req_tuser,
   output frame_type   frame,
   input  logic        frame_ready
);

   logic        stage_valid_ff, stage_valid_in;
   logic [10:0] len_ff;
   logic [31:0] magic_ff;
   logic [7:0]  type_ff, x_ff, y_ff, r_ff;
   logic [7:0]  r_in;

   logic        take, advance, msg_ok;
   logic [7:0]  w_mag;
   logic [23:0] r_prod;
   logic [6:0]  r_quot;

   logic signed [9:0] xe, ye, re;
   logic signed [9:0] v_fl, v_fr, v_rr, v_rl;
   logic [7:0]        s_fl, s_fr, s_rr, s_rl;

   // rotation term 58*w/100, computed on the way into the input register
   always_comb begin
      w_mag  = req_tdata[66] ? (8'd0 - req_tdata[66:59]) : req_tdata[66:59];
      r_prod = {16'd0, w_mag} * {8'd0, RATE_RECIP};
      r_quot = r_prod[22:16];
      r_in   = req_tdata[66] ? (8'd0 - {1'b0, r_quot}) : {1'b0, r_quot};
   end

   assign advance    = stage_valid_ff && (!frame.valid || frame_ready);
   assign req_tready = !stage_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         len_ff   <= req_tdata[10:0];
         magic_ff <= req_tdata[42:11];
         type_ff  <= req_tuser;
         x_ff     <= req_tdata[50:43];
         y_ff     <= req_tdata[58:51];
         r_ff     <= r_in;
      end
   end

   always_comb begin
      xe   = {{2{x_ff[7]}}, x_ff};
      ye   = {{2{y_ff[7]}}, y_ff};
      re   = {{2{r_ff[7]}}, r_ff};
      v_fl = xe - ye - re;
      v_fr = xe + ye + re;
      v_rr = xe - ye + re;
      v_rl = xe + ye - re;
   end

   dct_wheel u_wheel_fl (.vel(v_fl), .speed(s_fl));
   dct_wheel u_wheel_fr (.vel(v_fr), .speed(s_fr));
   dct_wheel u_wheel_rr (.vel(v_rr), .speed(s_rr));
   dct_wheel u_wheel_rl (.vel(v_rl), .speed(s_rl));

   assign msg_ok = (len_ff >= MIN_MSG_LEN) && (magic_ff == FRAME_MAGIC);

   always_comb begin
      frame.body_len = BODY_LEN_NONE;
      frame.body     = '0;
      if (msg_ok) begin
         case (type_ff)
            MSG_CMD0, MSG_CMD1, MSG_HORN, MSG_CMD4, MSG_CMD5,
            MSG_CMD8, MSG_CMD9, MSG_CMD10: begin
               frame.body_len = BODY_LEN_OP;
               frame.body[0]  = type_ff;
            end
            MSG_MOTOR: begin
               frame.body_len = BODY_LEN_MOTOR;
               frame.body[0]  = type_ff;
               frame.body[1]  = x_ff;
               frame.body[2]  = y_ff;
            end
            MSG_DRIVE, MSG_DRIVE_ALT: begin
               frame.body_len = BODY_LEN_DRIVE;
               frame.body[0]  = type_ff;
               frame.body[1]  = s_fl;
               frame.body[2]  = s_fr;
               frame.body[3]  = s_rr;
               frame.body[4]  = s_rl;
            end
            // debug toggle, negative and undefined types give no frame
            default: begin
               frame.body_len = BODY_LEN_NONE;
            end
         endcase
      end
      frame.valid = stage_valid_ff && (frame.body_len != BODY_LEN_NONE);
   end

endmodule

`default_nettype wire

FILE: design/dct_serial.sv
// frame shift register: prepends the magic bytes and sends one byte per word
// depends on dct_pkg
`timescale 1ns / 1ps
`default_nettype none

module dct_serial
   import dct_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  frame_type frame,
   output logic      frame_ready,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic      rsp_tlast
);

   logic [FRAME_MAX-1:0][7:0] bytes_ff, bytes_in;
   logic [3:0]                left_ff, left_in;
   logic                      out_take, load;

   assign rsp_tvalid  = (left_ff != 4'd0);
   assign rsp_tlast   = (left_ff == 4'd1);
   assign rsp_tdata   = bytes_ff[0];
   assign out_take    = rsp_tvalid && rsp_tready;
   // free now, or the last byte leaves in this cycle
   assign frame_ready = (left_ff == 4'd0) || (out_take && rsp_tlast);
   assign load        = frame.valid && frame_ready;

   always_comb begin
      left_in  = left_ff;
      bytes_in = bytes_ff;
      if (load) begin
         left_in  = 4'(FRAME_HEAD_LEN) + {1'b0, frame.body_len};
         bytes_in = {frame.body, FRAME_MAGIC[7:0], FRAME_MAGIC[15:8],
                     FRAME_MAGIC[23:16], FRAME_MAGIC[31:24]};
      end else if (out_take) begin
         left_in  = left_ff - 4'd1;
         bytes_in = bytes_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 4'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
   end

endmodule

`default_nettype wire

FILE: design/dct_checker.sv
// port-level checks of the drive command translator, bound to the top level
// depends on dct_pkg and drive_command_translator_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "drive_command_translator_core_macros.svh"

module dct_checker
   import dct_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   `DCT_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_tvalid, "output valid right after reset")
   `DCT_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_tready, "input not ready after reset")
   `DCT_ASSERT(a_rsp_hold,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled word changed")
   `DCT_ASSERT(a_frame_unbroken, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid,
      "gap inside a frame")
   `DCT_ASSERT(a_frame_start,
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || rsp_tdata == FRAME_MAGIC[31:24],
      "frame does not open with magic")

endmodule

bind drive_command_translator_core dct_checker u_dct_checker (.*);

`default_nettype wire
